// File: hw/rtl/min_max_svpwm_triangle_modulator_unit_defines.svh
// Assertion macros used by the checker file of the modulator.
`ifndef MIN_MAX_SVPWM_TRIANGLE_MODULATOR_UNIT_DEFINES_SVH
`define MIN_MAX_SVPWM_TRIANGLE_MODULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMSVPWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modulator check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define MMSVPWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modulator check failed: next-cycle implication");

`endif

// File: hw/rtl/mmsvpwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmsvpwm_pkg;

    // Field widths
    localparam int REF_BITS       = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int DUTY_BITS      = 18;
    localparam int OUT_COUNT_BITS = 16;
    localparam int GATE_BITS      = 6;

    // 2/sqrt(3) held as K_SCALE / 2^K_SHIFT
    localparam int                 K_BITS  = 25;
    localparam logic [K_BITS-1:0]  K_SCALE = 25'd19372660;
    localparam int                 K_SHIFT = 24;

    // K * period product, split in two chunks for the shared multiplier
    localparam int KP_BITS    = K_BITS + PERIOD_BITS;
    localparam int KP_LO_BITS = 21;
    localparam int KP_HI_BITS = KP_BITS - KP_LO_BITS;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd1000;

    // Stream packing
    localparam int S_DATA_BITS = 56;
    localparam int M_DATA_BITS = 24;
    localparam int S_EN_BIT    = 0;
    localparam int S_REF_A_LSB = 1;
    localparam int S_REF_B_LSB = 17;
    localparam int S_REF_C_LSB = 33;
    localparam int M_COUNT_LSB = 6;
    localparam int M_UPD_BIT   = 22;
    localparam int M_PAD_BITS  = M_DATA_BITS - M_UPD_BIT - 1;

    // Phase index codes
    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_C = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       load_direct;
        logic       minmax;
        logic       wsum;
        logic       mul_hi;
        logic       mul_lo;
        logic       acc;
        logic       duty;
        logic       load_final;
        logic [1:0] phase;
    } mmsvpwm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic update_hit;
        logic out_free;
    } mmsvpwm_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/mmsvpwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mmsvpwm_ctrl
    import mmsvpwm_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  mmsvpwm_status_t      status,
    output mmsvpwm_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MINMAX = 3'd1;
    localparam logic [2:0] ST_WSUM   = 3'd2;
    localparam logic [2:0] ST_MUL_HI = 3'd3;
    localparam logic [2:0] ST_MUL_LO = 3'd4;
    localparam logic [2:0] ST_ACC    = 3'd5;
    localparam logic [2:0] ST_DUTY   = 3'd6;
    localparam logic [2:0] ST_GATES  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       accept;

    // Take an item only when idle and the output register can take its result
    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.phase  = phase_reg;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (status.update_hit)
                    begin
                        state_next = ST_MINMAX;
                        phase_next = PHASE_A;
                    end
                    else
                    begin
                        cmd.load_direct = 1'b1;
                    end
                end
            end
            ST_MINMAX:
            begin
                cmd.minmax = 1'b1;
                state_next = ST_WSUM;
            end
            ST_WSUM:
            begin
                cmd.wsum   = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_DUTY;
            end
            ST_DUTY:
            begin
                cmd.duty = 1'b1;
                if (phase_reg == PHASE_C)
                begin
                    state_next = ST_GATES;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    state_next = ST_MUL_HI;
                end
            end
            ST_GATES:
            begin
                if (status.out_free)
                begin
                    cmd.load_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PHASE_A;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/mmsvpwm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mmsvpwm_dp
    import mmsvpwm_pkg::*;
#(
    parameter int COUNT_BITS    = 16,
    parameter int REF_FRAC_BITS = 14
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [PERIOD_BITS-1:0] cfg_data,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    input  wire logic                   m_tready,
    output logic                        m_tvalid,
    output logic [M_DATA_BITS-1:0]      m_tdata,
    input  mmsvpwm_cmd_t                cmd,
    output mmsvpwm_status_t             status
);

    localparam int CW      = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
    localparam int V_W     = (REF_FRAC_BITS + 2 < REF_BITS) ? REF_FRAC_BITS + 2 : REF_BITS;
    localparam int S_W     = V_W + 1;
    localparam int W_W     = V_W + 2;
    localparam int MUL_W   = W_W + KP_LO_BITS + 1;
    localparam int ACC_W   = W_W + KP_BITS + 1;
    localparam int Q_SHIFT = REF_FRAC_BITS + K_SHIFT + 1;
    localparam int DQ_W    = DUTY_BITS + 2;
    localparam int CMP_W   = ((COUNT_BITS > DUTY_BITS) ? COUNT_BITS : DUTY_BITS) + 1;

    localparam logic signed [32:0] REF_ONE     = 33'sd1 <<< REF_FRAC_BITS;
    localparam logic signed [32:0] REF_NEG_ONE = -REF_ONE;

    // Clamp a raw reference to +-1.0
    function automatic logic signed [V_W-1:0] clamp_ref(input logic signed [REF_BITS-1:0] raw);
        logic signed [32:0] x;
        x = 33'(raw);
        if (x > REF_ONE)
        begin
            x = REF_ONE;
        end
        else if (x < REF_NEG_ONE)
        begin
            x = REF_NEG_ONE;
        end
        return x[V_W-1:0];
    endfunction

    // Upper gate: duty at or above the count, signed compare
    function automatic logic gate_up(input logic signed [DUTY_BITS-1:0] d,
                                     input logic [COUNT_BITS-1:0] c);
        logic signed [CMP_W-1:0] de;
        logic signed [CMP_W-1:0] ce;
        de = CMP_W'(d);
        ce = $signed(CMP_W'(c));
        return de >= ce;
    endfunction

    // Carrier and duty state
    logic [PERIOD_BITS-1:0]       period_reg;
    logic [COUNT_BITS-1:0]        counter_reg;
    logic                         down_reg;
    logic                         down_next;
    logic signed [DUTY_BITS-1:0]  duty_reg [3];

    // Per-update working registers
    logic                         enable_reg;
    logic signed [V_W-1:0]        v_reg [3];
    logic signed [S_W-1:0]        sum_reg;
    logic [KP_BITS-1:0]           kp_reg;
    logic signed [W_W-1:0]        w_reg [3];
    logic signed [MUL_W-1:0]      mul_reg;
    logic signed [MUL_W-1:0]      prod_hi_reg;
    logic signed [ACC_W-1:0]      acc_reg;

    // Output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [M_DATA_BITS-1:0]       m_data_reg;

    // Counter step
    logic [COUNT_BITS-1:0]        cnt_step;
    logic [CW-1:0]                step_w;
    logic [CW-1:0]                period_w;
    logic                         step_hit;
    logic                         step_ge;
    logic                         step_zero;

    assign cnt_step  = down_reg ? counter_reg - COUNT_BITS'(1) : counter_reg + COUNT_BITS'(1);
    assign step_w    = CW'(cnt_step);
    assign period_w  = CW'(period_reg);
    assign step_hit  = (step_w == period_w);
    assign step_ge   = (step_w >= period_w);
    assign step_zero = (cnt_step == '0);

    // Reaching zero turns up and wins over reaching the period
    always_comb
    begin
        priority if (step_zero)
        begin
            down_next = 1'b0;
        end
        else if (step_ge)
        begin
            down_next = 1'b1;
        end
        else
        begin
            down_next = down_reg;
        end
    end

    // Min and max of the clamped references
    logic signed [V_W-1:0] lo_ab;
    logic signed [V_W-1:0] lo_all;
    logic signed [V_W-1:0] hi_ab;
    logic signed [V_W-1:0] hi_all;

    assign lo_ab  = (v_reg[1] < v_reg[0]) ? v_reg[1] : v_reg[0];
    assign lo_all = (v_reg[2] < lo_ab) ? v_reg[2] : lo_ab;
    assign hi_ab  = (v_reg[1] > v_reg[0]) ? v_reg[1] : v_reg[0];
    assign hi_all = (v_reg[2] > hi_ab) ? v_reg[2] : hi_ab;

    // Shared multiplier: w times one chunk of K * period
    logic signed [KP_LO_BITS:0]   kp_chunk;
    logic signed [W_W-1:0]        w_sel;
    logic signed [MUL_W-1:0]      mul_prod;

    assign kp_chunk = cmd.mul_hi
                      ? $signed({1'b0, KP_LO_BITS'(kp_reg[KP_BITS-1:KP_LO_BITS])})
                      : $signed({1'b0, kp_reg[KP_LO_BITS-1:0]});
    assign w_sel    = w_reg[cmd.phase];
    assign mul_prod = MUL_W'(w_sel) * MUL_W'(kp_chunk);

    // Recombine the two partial products
    logic signed [ACC_W-1:0]      acc_next;

    assign acc_next = (ACC_W'(prod_hi_reg) <<< KP_LO_BITS) + ACC_W'(mul_reg);

    // duty = floor((P + 1 + floor(K*w*P / 2^Q_SHIFT)) / 2)
    logic signed [ACC_W-1:0]      q_full;
    logic signed [DQ_W-1:0]       q_val;
    logic signed [DQ_W-1:0]       duty_sum;
    logic signed [DUTY_BITS-1:0]  duty_new;

    assign q_full   = acc_reg >>> Q_SHIFT;
    assign q_val    = q_full[DQ_W-1:0];
    assign duty_sum = $signed(DQ_W'(period_reg)) + $signed(DQ_W'(1)) + q_val;
    assign duty_new = duty_sum[DUTY_BITS:1];

    // Gate compare against the count after this tick
    logic [COUNT_BITS-1:0]        cmp_count;
    logic [CW-1:0]                cmp_count_w;
    logic                         gate_en;
    logic                         up_a;
    logic                         up_b;
    logic                         up_c;
    logic [GATE_BITS-1:0]         gates;
    logic                         out_load;

    assign cmp_count   = cmd.load_direct ? cnt_step : counter_reg;
    assign cmp_count_w = CW'(cmp_count);
    assign gate_en     = cmd.load_direct ? s_tdata[S_EN_BIT] : enable_reg;
    assign up_a        = gate_up(duty_reg[0], cmp_count);
    assign up_b        = gate_up(duty_reg[1], cmp_count);
    assign up_c        = gate_up(duty_reg[2], cmp_count);
    assign gates       = gate_en ? {~up_c, up_c, ~up_b, up_b, ~up_a, up_a} : '0;
    assign out_load    = cmd.load_direct || cmd.load_final;

    // Output register handshake
    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            counter_reg   <= '0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                counter_reg <= cnt_step;
                down_reg    <= down_next;
            end
            if (cmd.duty)
            begin
                duty_reg[cmd.phase] <= duty_new;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            enable_reg <= s_tdata[S_EN_BIT];
            v_reg[0]   <= clamp_ref(s_tdata[S_REF_A_LSB +: REF_BITS]);
            v_reg[1]   <= clamp_ref(s_tdata[S_REF_B_LSB +: REF_BITS]);
            v_reg[2]   <= clamp_ref(s_tdata[S_REF_C_LSB +: REF_BITS]);
        end
        if (cmd.minmax)
        begin
            sum_reg <= S_W'(lo_all) + S_W'(hi_all);
            kp_reg  <= KP_BITS'(K_SCALE) * KP_BITS'(period_reg);
        end
        if (cmd.wsum)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= (W_W'(v_reg[i]) <<< 1) - W_W'(sum_reg);
            end
        end
        if (cmd.mul_hi || cmd.mul_lo)
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.mul_lo)
        begin
            prod_hi_reg <= mul_reg;
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_next;
        end
        if (out_load)
        begin
            m_data_reg <= {M_PAD_BITS'(0), cmd.load_final,
                           cmp_count_w[OUT_COUNT_BITS-1:0], gates};
        end
    end

    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = m_data_reg;
    assign status.update_hit = step_hit;
    assign status.out_free   = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

// File: hw/rtl/min_max_svpwm_triangle_modulator_unit.sv
// On an ordinary carrier tick the result is registered as the item is accepted.
// When the count reaches the period, min/max and weighted sum come first, then the
//   shared multiplier runs two partial products per phase over the three phases.
// Throughput: one item per cycle while the output is free, none in an update.
// Reset (rst_n, async, active low): count 0 counting up, duties 0, period 1000,
//   output empty.
`timescale 1ns / 1ps
`default_nettype none

module min_max_svpwm_triangle_modulator_unit
    import mmsvpwm_pkg::*;
#(
    parameter int COUNT_BITS    = 16,
    parameter int REF_FRAC_BITS = 14
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Carrier period register write
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [PERIOD_BITS-1:0] cfg_data,
    // Tick items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [0] enable, [16:1] ref_a, [32:17] ref_b, [48:33] ref_c, [55:49] zero
    input  wire logic [S_DATA_BITS-1:0] s_axis_tdata,
    // Result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [0] gate_a_upper, [1] gate_a_lower, [2] gate_b_upper, [3] gate_b_lower,
    // [4] gate_c_upper, [5] gate_c_lower, [21:6] carrier_count,
    // [22] duties_updated, [23] zero
    output logic [M_DATA_BITS-1:0]      m_axis_tdata
);

    mmsvpwm_cmd_t    cmd;
    mmsvpwm_status_t status;

    // Period register is always writable
    assign cfg_ready = 1'b1;

    mmsvpwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mmsvpwm_dp #(
        .COUNT_BITS    (COUNT_BITS),
        .REF_FRAC_BITS (REF_FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .s_tdata  (s_axis_tdata),
        .m_tready (m_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tdata  (m_axis_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/mmsvpwm_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "min_max_svpwm_triangle_modulator_unit_defines.svh"

module mmsvpwm_chk
    import mmsvpwm_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [M_DATA_BITS-1:0] m_axis_tdata
);

    // A stalled result holds
    `MMSVPWM_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Gate pairs are all off, or every pair is complementary
    `MMSVPWM_ASSERT_IMP(a_gate_pairs, clk, rst_n, m_axis_tvalid, (m_axis_tdata[5:0] == 6'b0) || ((m_axis_tdata[0] != m_axis_tdata[1]) && (m_axis_tdata[2] != m_axis_tdata[3]) && (m_axis_tdata[4] != m_axis_tdata[5])))

    // A new item is taken only if a waiting result leaves in the same cycle
    `MMSVPWM_ASSERT_IMP(a_no_overrun, clk, rst_n, s_axis_tready && m_axis_tvalid, m_axis_tready)

endmodule

bind min_max_svpwm_triangle_modulator_unit mmsvpwm_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
